/* design/greedy_box_nms_unit_assert.svh */
// Assertion macros for the greedy box suppression unit
`ifndef GREEDY_BOX_NMS_UNIT_ASSERT_SVH
`define GREEDY_BOX_NMS_UNIT_ASSERT_SVH

// same-cycle implication
`define GNMS_ASSERT_HOLDS(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
      else $error("gnms assertion failed");

// next-cycle implication
`define GNMS_ASSERT_NEXT(label, clk, rst, cond, conseq) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (conseq)) \
      else $error("gnms assertion failed");

`endif

/* design/gnms_pkg.sv */
// Shared constants and types of the greedy box suppression unit
`default_nettype none
package gnms_pkg;
   localparam int MaxBoxes   = 64;
   localparam int SlotW      = $clog2(MaxBoxes);
   localparam int CountW     = SlotW + 1;
   localparam int CoordW     = 16;
   localparam int ScoreW     = 16;
   localparam int ThrW       = 17;
   localparam int QueueDepth = 2;
   localparam logic [ThrW-1:0] ThrReset   = 17'd32768;
   localparam logic [2:0]      CmpLatency = 3'd5;

   typedef struct packed {
      logic signed [CoordW-1:0] left;
      logic signed [CoordW-1:0] top;
      logic signed [CoordW-1:0] right;
      logic signed [CoordW-1:0] bottom;
      logic [ScoreW-1:0]        score;
      logic [SlotW-1:0]         slot;
      logic                     last;
      logic                     drop;
   } item_type;

   typedef struct packed {
      logic signed [CoordW-1:0] left;
      logic signed [CoordW-1:0] top;
      logic signed [CoordW-1:0] right;
      logic signed [CoordW-1:0] bottom;
      logic [ScoreW-1:0]        score;
      logic [SlotW-1:0]         slot;
      logic                     overflowed;
      logic                     last;
   } result_type;

   typedef struct packed {
      logic loading;
   } back_stat_type;
endpackage
`default_nettype wire

/* design/gnms_front.sv */
// Front end: takes requests, numbers them within the set and flags overflow drops
`default_nettype none
module gnms_front (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              push,
   output logic                                   full,
   input  wire logic signed [gnms_pkg::CoordW-1:0] box_left,
   input  wire logic signed [gnms_pkg::CoordW-1:0] box_top,
   input  wire logic signed [gnms_pkg::CoordW-1:0] box_right,
   input  wire logic signed [gnms_pkg::CoordW-1:0] box_bottom,
   input  wire logic [gnms_pkg::ScoreW-1:0]        box_score,
   input  wire logic                              last_in,
   output logic                                   q_push,
   output gnms_pkg::item_type                     q_item,
   input  wire logic                              q_full
);
   logic [gnms_pkg::CountW-1:0] count_ff, count_in;
   logic                        drop;

   assign full   = q_full;
   assign q_push = push & ~q_full;
   assign drop   = count_ff >= gnms_pkg::CountW'(gnms_pkg::MaxBoxes);

   always_comb begin
      q_item.left   = box_left;
      q_item.top    = box_top;
      q_item.right  = box_right;
      q_item.bottom = box_bottom;
      q_item.score  = box_score;
      q_item.slot   = count_ff[gnms_pkg::SlotW-1:0];
      q_item.last   = last_in;
      q_item.drop   = drop;
   end

   always_comb begin
      count_in = count_ff;
      if (q_push) begin
         if (last_in) begin
            count_in = '0;
         end else if (!drop) begin
            count_in = count_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end
endmodule
`default_nettype wire

/* design/gnms_fifo.sv */
// Short request queue between front and back
`default_nettype none
module gnms_fifo (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               wr_en,
   input  wire gnms_pkg::item_type wr_item,
   output logic                    full,
   input  wire logic               rd_en,
   output gnms_pkg::item_type      rd_item,
   output logic                    empty
);
   localparam int PtrW = $clog2(gnms_pkg::QueueDepth);

   gnms_pkg::item_type          mem_ff [gnms_pkg::QueueDepth];
   logic [PtrW-1:0]             wr_ptr_ff, rd_ptr_ff;
   logic [PtrW:0]               count_ff;
   logic                        do_wr, do_rd;

   assign full    = count_ff == (PtrW+1)'(gnms_pkg::QueueDepth);
   assign empty   = count_ff == '0;
   assign do_wr   = wr_en & ~full;
   assign do_rd   = rd_en & ~empty;
   assign rd_item = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_wr) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (do_rd) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (do_wr && !do_rd) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_rd && !do_wr) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end
endmodule
`default_nettype wire

/* design/gnms_back.sv */
// Back end: box store, rank sort, pairwise IoU suppression and result register
`default_nettype none
module gnms_back (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic [gnms_pkg::ThrW-1:0]   thr,
   input  wire gnms_pkg::item_type          q_item,
   input  wire logic                        q_empty,
   output logic                             q_pop,
   output gnms_pkg::result_type             rsp,
   output logic                             rsp_valid,
   input  wire logic                        rsp_pop,
   output gnms_pkg::back_stat_type          stat
);
   localparam int SW = gnms_pkg::SlotW;
   localparam int CW = gnms_pkg::CountW;
   localparam int NB = gnms_pkg::MaxBoxes;

   typedef enum logic [11:0] {
      S_LOAD    = 12'b0000_0000_0001,
      S_RANK_RD = 12'b0000_0000_0010,
      S_RANK    = 12'b0000_0000_0100,
      S_NMS_I   = 12'b0000_0000_1000,
      S_NMS_IW  = 12'b0000_0001_0000,
      S_NMS_J   = 12'b0000_0010_0000,
      S_NMS_JW  = 12'b0000_0100_0000,
      S_NMS_JE  = 12'b0000_1000_0000,
      S_CMP     = 12'b0001_0000_0000,
      S_EMIT_I  = 12'b0010_0000_0000,
      S_EMIT_W  = 12'b0100_0000_0000,
      S_EMIT    = 12'b1000_0000_0000
   } state_type;

   state_type          state_ff, state_in;
   logic [CW-1:0]      n_ff, n_in, i_ff, i_in, j_ff, j_in, surv_ff, surv_in;
   logic [SW-1:0]      rank_ff, rank_in, slot_a_ff, slot_a_in, slot_b_ff, slot_b_in;
   logic [2:0]         cnt_ff, cnt_in;
   logic               ovf_ff, ovf_in;
   logic [NB-1:0]      alive_ff, alive_in;
   gnms_pkg::result_type out_ff, out_in;
   logic               out_valid_ff, out_valid_in;

   logic [63:0]        edge_mem  [NB];
   logic [15:0]        score_mem [NB];
   logic [SW-1:0]      order_mem [NB];
   logic [63:0]        edge_a_ff, edge_b_ff;
   logic [15:0]        score_a_ff, score_b_ff;
   logic [SW-1:0]      order_q_ff;
   logic [SW-1:0]      score_addr_b, order_addr;
   logic               load_wr, order_wr, inc, out_load;
   logic [SW-1:0]      rank_fin;

   // comparison pipeline
   logic signed [16:0] dw_ff, dh_ff;
   logic [15:0]        wa_ff, ha_ff, wb_ff, hb_ff;
   logic               ovl1_ff, ovl2_ff, ovl3_ff, ovl4_ff, sup_ff;
   logic [31:0]        inter2_ff, area_a_ff, area_b_ff, inter3_ff, inter4_ff;
   logic [32:0]        uni_ff;
   logic [33:0]        pp_lo_ff;
   logic [32:0]        pp_hi_ff;
   logic signed [15:0] al, at, ar, ab, bl, bt, br, bb;
   logic signed [15:0] min_r, max_l, min_b, max_t;
   logic signed [16:0] dw_c, dh_c, wa_c, ha_c, wb_c, hb_c;
   logic [49:0]        rhs;
   logic [47:0]        lhs;

   assign stat.loading = state_ff == S_LOAD;
   assign q_pop        = (state_ff == S_LOAD) & ~q_empty;
   assign load_wr      = q_pop & ~q_item.drop;
   assign inc          = (score_b_ff > score_a_ff) ||
                         ((score_b_ff == score_a_ff) && (j_ff < i_ff));
   assign rank_fin     = rank_ff + SW'(inc);
   assign order_wr     = (state_ff == S_RANK) && (j_ff == n_ff - 1'b1);
   assign out_load     = (state_ff == S_EMIT) && (!out_valid_ff || rsp_pop);
   assign order_addr   = (state_ff == S_NMS_J) ? j_ff[SW-1:0] : i_ff[SW-1:0];
   assign rsp          = out_ff;
   assign rsp_valid    = out_valid_ff;

   always_comb begin
      if (state_ff == S_RANK_RD) begin
         score_addr_b = '0;
      end else if (state_ff == S_RANK) begin
         score_addr_b = j_ff[SW-1:0] + 1'b1;
      end else begin
         score_addr_b = slot_b_ff;
      end
   end

   // memories
   always_ff @(posedge clock) begin
      if (load_wr) begin
         edge_mem[q_item.slot]  <= {q_item.bottom, q_item.right, q_item.top, q_item.left};
         score_mem[q_item.slot] <= q_item.score;
      end
      if (order_wr) begin
         order_mem[rank_fin] <= i_ff[SW-1:0];
      end
      edge_a_ff  <= edge_mem[slot_a_ff];
      edge_b_ff  <= edge_mem[slot_b_ff];
      score_a_ff <= score_mem[i_ff[SW-1:0]];
      score_b_ff <= score_mem[score_addr_b];
      order_q_ff <= order_mem[order_addr];
   end

   // IoU test, five stages
   always_comb begin
      al = edge_a_ff[15:0];  at = edge_a_ff[31:16];
      ar = edge_a_ff[47:32]; ab = edge_a_ff[63:48];
      bl = edge_b_ff[15:0];  bt = edge_b_ff[31:16];
      br = edge_b_ff[47:32]; bb = edge_b_ff[63:48];
      min_r = (ar < br) ? ar : br;
      max_l = (al > bl) ? al : bl;
      min_b = (ab < bb) ? ab : bb;
      max_t = (at > bt) ? at : bt;
      dw_c = 17'(min_r) - 17'(max_l);
      dh_c = 17'(min_b) - 17'(max_t);
      wa_c = 17'(ar) - 17'(al);
      ha_c = 17'(ab) - 17'(at);
      wb_c = 17'(br) - 17'(bl);
      hb_c = 17'(bb) - 17'(bt);
      rhs  = {pp_hi_ff, 17'b0} + 50'(pp_lo_ff);
      lhs  = {inter4_ff, 16'b0};
   end

   always_ff @(posedge clock) begin
      dw_ff     <= dw_c;
      dh_ff     <= dh_c;
      wa_ff     <= wa_c[15:0];
      ha_ff     <= ha_c[15:0];
      wb_ff     <= wb_c[15:0];
      hb_ff     <= hb_c[15:0];
      ovl1_ff   <= (dw_c > 17'sd0) && (dh_c > 17'sd0);
      inter2_ff <= 32'(dw_ff[15:0]) * 32'(dh_ff[15:0]);
      area_a_ff <= 32'(wa_ff) * 32'(ha_ff);
      area_b_ff <= 32'(wb_ff) * 32'(hb_ff);
      ovl2_ff   <= ovl1_ff;
      uni_ff    <= 33'(area_a_ff) + 33'(area_b_ff) - 33'(inter2_ff);
      inter3_ff <= inter2_ff;
      ovl3_ff   <= ovl2_ff;
      pp_lo_ff  <= 34'(thr) * 34'(uni_ff[16:0]);
      pp_hi_ff  <= 33'(thr) * 33'(uni_ff[32:17]);
      inter4_ff <= inter3_ff;
      ovl4_ff   <= ovl3_ff;
      sup_ff    <= ovl4_ff ? (50'(lhs) >= rhs) : (thr == '0);
   end

   // sequencer
   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      i_in      = i_ff;
      j_in      = j_ff;
      surv_in   = surv_ff;
      rank_in   = rank_ff;
      slot_a_in = slot_a_ff;
      slot_b_in = slot_b_ff;
      cnt_in    = cnt_ff;
      ovf_in    = ovf_ff;
      alive_in  = alive_ff;
      out_in    = out_ff;
      unique case (state_ff)
         S_LOAD: begin
            if (q_pop) begin
               if (q_item.drop) begin
                  ovf_in = 1'b1;
               end else begin
                  n_in = CW'(q_item.slot) + 1'b1;
               end
               if (q_item.last) begin
                  i_in     = '0;
                  state_in = S_RANK_RD;
               end
            end
         end
         S_RANK_RD: begin
            j_in     = '0;
            rank_in  = '0;
            state_in = S_RANK;
         end
         S_RANK: begin
            if (j_ff == n_ff - 1'b1) begin
               if (i_ff == n_ff - 1'b1) begin
                  i_in    = '0;
                  surv_in = n_ff;
                  for (int k = 0; k < NB; k++) begin
                     alive_in[k] = CW'(k) < n_ff;
                  end
                  state_in = S_NMS_I;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = S_RANK_RD;
               end
            end else begin
               j_in    = j_ff + 1'b1;
               rank_in = rank_fin;
            end
         end
         S_NMS_I: begin
            priority if (i_ff == n_ff) begin
               i_in     = '0;
               state_in = S_EMIT_I;
            end else if (!alive_ff[i_ff[SW-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = S_NMS_IW;
            end
         end
         S_NMS_IW: begin
            slot_a_in = order_q_ff;
            j_in      = i_ff + 1'b1;
            state_in  = S_NMS_J;
         end
         S_NMS_J: begin
            priority if (j_ff == n_ff) begin
               i_in     = i_ff + 1'b1;
               state_in = S_NMS_I;
            end else if (!alive_ff[j_ff[SW-1:0]]) begin
               j_in = j_ff + 1'b1;
            end else begin
               state_in = S_NMS_JW;
            end
         end
         S_NMS_JW: begin
            slot_b_in = order_q_ff;
            state_in  = S_NMS_JE;
         end
         S_NMS_JE: begin
            cnt_in   = '0;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (cnt_ff == gnms_pkg::CmpLatency) begin
               if (sup_ff) begin
                  alive_in[j_ff[SW-1:0]] = 1'b0;
                  surv_in = surv_ff - 1'b1;
               end
               j_in     = j_ff + 1'b1;
               state_in = S_NMS_J;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         S_EMIT_I: begin
            priority if (i_ff == n_ff) begin
               n_in     = '0;
               ovf_in   = 1'b0;
               alive_in = '0;
               state_in = S_LOAD;
            end else if (!alive_ff[i_ff[SW-1:0]]) begin
               i_in = i_ff + 1'b1;
            end else begin
               state_in = S_EMIT_W;
            end
         end
         S_EMIT_W: begin
            slot_b_in = order_q_ff;
            cnt_in    = '0;
            state_in  = S_EMIT;
         end
         S_EMIT: begin
            // wait, with cnt_ff at zero, for the edge and score reads
            if (cnt_ff == '0) begin
               cnt_in = 3'd1;
            end else if (out_load) begin
               out_in.left       = edge_b_ff[15:0];
               out_in.top        = edge_b_ff[31:16];
               out_in.right      = edge_b_ff[47:32];
               out_in.bottom     = edge_b_ff[63:48];
               out_in.score      = score_b_ff;
               out_in.slot       = slot_b_ff;
               out_in.overflowed = ovf_ff;
               out_in.last       = surv_ff == CW'(1);
               surv_in           = surv_ff - 1'b1;
               i_in              = i_ff + 1'b1;
               state_in          = S_EMIT_I;
            end
         end
         default: state_in = S_LOAD;
      endcase
   end

   assign out_valid_in = (out_load && cnt_ff != '0) | (out_valid_ff & ~rsp_pop);

   always_ff @(posedge clock) begin
      out_ff    <= out_in;
      slot_a_ff <= slot_a_in;
      slot_b_ff <= slot_b_in;
      rank_ff   <= rank_in;
      if (reset) begin
         state_ff     <= S_LOAD;
         n_ff         <= '0;
         i_ff         <= '0;
         j_ff         <= '0;
         surv_ff      <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         alive_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         n_ff         <= n_in;
         i_ff         <= i_in;
         j_ff         <= j_in;
         surv_ff      <= surv_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         alive_ff     <= alive_in;
         out_valid_ff <= out_valid_in;
      end
   end
endmodule
`default_nettype wire

/* design/greedy_box_nms_unit.sv */
// Top level of the greedy box suppression unit
//
//   channel   handshake         payload
//   request   push / full       req_box_*, req_last_in
//   result    empty / pop       rsp_out_*, rsp_arrival_slot, rsp_overflowed, rsp_last_out
//   csr       csr_wr_en         csr_wr_data (IoU threshold)
//
// Loading takes one request per cycle while the back end is in its load state; a set
// of boxes is then rank sorted on the score store, each pair of live boxes is checked in
// the IoU pipeline, boxes already suppressed are skipped and each survivor is emitted.
// The single back end sequencer steps through these phases.
// Reset is synchronous; the stores need no clearing pass, threshold returns to 0.5.
// Requests queue in front while the back end works; results wait in one register.
`default_nettype none
`include "greedy_box_nms_unit_assert.svh"
module greedy_box_nms_unit (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               push,
   output logic                                    full,
   input  wire logic signed [gnms_pkg::CoordW-1:0] req_box_left,
   input  wire logic signed [gnms_pkg::CoordW-1:0] req_box_top,
   input  wire logic signed [gnms_pkg::CoordW-1:0] req_box_right,
   input  wire logic signed [gnms_pkg::CoordW-1:0] req_box_bottom,
   input  wire logic [gnms_pkg::ScoreW-1:0]        req_box_score,
   input  wire logic                               req_last_in,
   output logic                                    empty,
   input  wire logic                               pop,
   output logic signed [gnms_pkg::CoordW-1:0]      rsp_out_left,
   output logic signed [gnms_pkg::CoordW-1:0]      rsp_out_top,
   output logic signed [gnms_pkg::CoordW-1:0]      rsp_out_right,
   output logic signed [gnms_pkg::CoordW-1:0]      rsp_out_bottom,
   output logic [gnms_pkg::ScoreW-1:0]             rsp_out_score,
   output logic [gnms_pkg::SlotW-1:0]              rsp_arrival_slot,
   output logic                                    rsp_overflowed,
   output logic                                    rsp_last_out,
   input  wire logic                               csr_wr_en,
   input  wire logic [gnms_pkg::ThrW-1:0]          csr_wr_data
);
   logic [gnms_pkg::ThrW-1:0] thr_ff;
   gnms_pkg::item_type        f_item, q_item;
   gnms_pkg::result_type      rsp;
   gnms_pkg::back_stat_type   back_stat;
   logic                      q_push, q_full, q_pop, q_empty, rsp_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= gnms_pkg::ThrReset;
      end else if (csr_wr_en) begin
         thr_ff <= csr_wr_data;
      end
   end

   gnms_front u_front (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .full       (full),
      .box_left   (req_box_left),
      .box_top    (req_box_top),
      .box_right  (req_box_right),
      .box_bottom (req_box_bottom),
      .box_score  (req_box_score),
      .last_in    (req_last_in),
      .q_push     (q_push),
      .q_item     (f_item),
      .q_full     (q_full)
   );

   gnms_fifo u_fifo (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (q_push),
      .wr_item (f_item),
      .full    (q_full),
      .rd_en   (q_pop),
      .rd_item (q_item),
      .empty   (q_empty)
   );

   gnms_back u_back (
      .clock     (clock),
      .reset     (reset),
      .thr       (thr_ff),
      .q_item    (q_item),
      .q_empty   (q_empty),
      .q_pop     (q_pop),
      .rsp       (rsp),
      .rsp_valid (rsp_valid),
      .rsp_pop   (pop),
      .stat      (back_stat)
   );

   assign empty            = ~rsp_valid;
   assign rsp_out_left     = rsp.left;
   assign rsp_out_top      = rsp.top;
   assign rsp_out_right    = rsp.right;
   assign rsp_out_bottom   = rsp.bottom;
   assign rsp_out_score    = rsp.score;
   assign rsp_arrival_slot = rsp.slot;
   assign rsp_overflowed   = rsp.overflowed;
   assign rsp_last_out     = rsp.last;

   `GNMS_ASSERT_HOLDS(a_queue_no_overrun, clock, reset, q_push, !q_full)
   `GNMS_ASSERT_HOLDS(a_pop_only_loading, clock, reset, q_pop, back_stat.loading && !q_empty)
   `GNMS_ASSERT_NEXT(a_no_result_while_loading, clock, reset, empty && back_stat.loading, empty)
endmodule
`default_nettype wire

/* bench/tb_top.sv */
// Testbench for greedy_box_nms_unit: scoreboard prediction of greedy IoU suppression
`default_nettype none
class nms_scoreboard;
   logic signed [15:0] box_l[64], box_t[64], box_r[64], box_b[64];
   logic [15:0]        box_s[64];
   int                 box_n;
   bit                 dropped;
   logic [16:0]        thr;
   gnms_pkg::result_type survivors_q[$];
   int                 errors;

   function new();
      thr = gnms_pkg::ThrReset;
      box_n = 0;
      dropped = 0;
      errors = 0;
   endfunction

   function bit removes(int a, int b);
      int dw, dh;
      longint unsigned inter, area_a, area_b;
      dw = ((box_r[a] < box_r[b]) ? box_r[a] : box_r[b]) -
           ((box_l[a] > box_l[b]) ? box_l[a] : box_l[b]);
      dh = ((box_b[a] < box_b[b]) ? box_b[a] : box_b[b]) -
           ((box_t[a] > box_t[b]) ? box_t[a] : box_t[b]);
      if (dw <= 0 || dh <= 0) return thr == 0;
      inter  = longint'(dw) * longint'(dh);
      area_a = longint'(int'(box_r[a]) - int'(box_l[a])) *
               longint'(int'(box_b[a]) - int'(box_t[a]));
      area_b = longint'(int'(box_r[b]) - int'(box_l[b])) *
               longint'(int'(box_b[b]) - int'(box_t[b]));
      return (inter << 16) >= longint'(thr) * (area_a + area_b - inter);
   endfunction

   function void note_request(logic signed [15:0] l, t, r, b, logic [15:0] s, bit last);
      int rank[64];
      bit alive[64];
      int j, cur, kept, done;
      gnms_pkg::result_type res;
      if (box_n < 64) begin
         box_l[box_n] = l; box_t[box_n] = t; box_r[box_n] = r; box_b[box_n] = b;
         box_s[box_n] = s;
         box_n++;
      end else begin
         dropped = 1;
      end
      if (!last) return;
      for (int i = 0; i < box_n; i++) begin
         cur = i;
         j = i;
         while (j > 0 && box_s[rank[j-1]] < box_s[cur]) begin
            rank[j] = rank[j-1];
            j--;
         end
         rank[j] = cur;
      end
      for (int i = 0; i < box_n; i++) alive[i] = 1;
      for (int i = 0; i < box_n; i++)
         if (alive[i])
            for (int k = i + 1; k < box_n; k++)
               if (alive[k] && removes(rank[i], rank[k])) alive[k] = 0;
      kept = 0;
      for (int i = 0; i < box_n; i++) kept += alive[i];
      done = 0;
      for (int i = 0; i < box_n; i++) begin
         if (alive[i]) begin
            cur = rank[i];
            done++;
            res.left = box_l[cur]; res.top = box_t[cur];
            res.right = box_r[cur]; res.bottom = box_b[cur];
            res.score = box_s[cur];
            res.slot = cur[5:0];
            res.overflowed = dropped;
            res.last = (done == kept);
            survivors_q = {survivors_q, res};
         end
      end
      box_n = 0;
      dropped = 0;
   endfunction

   function void check_result(gnms_pkg::result_type got);
      gnms_pkg::result_type exp_r;
      if (survivors_q.size() == 0) begin
         $error("unexpected result left=%0d score=%0d", got.left, got.score);
         errors++;
         return;
      end
      exp_r = survivors_q.pop_front();
      if (got.left !== exp_r.left) begin
         $error("out_left expected %0d got %0d", exp_r.left, got.left); errors++;
      end
      if (got.top !== exp_r.top) begin
         $error("out_top expected %0d got %0d", exp_r.top, got.top); errors++;
      end
      if (got.right !== exp_r.right) begin
         $error("out_right expected %0d got %0d", exp_r.right, got.right); errors++;
      end
      if (got.bottom !== exp_r.bottom) begin
         $error("out_bottom expected %0d got %0d", exp_r.bottom, got.bottom); errors++;
      end
      if (got.score !== exp_r.score) begin
         $error("out_score expected %0d got %0d", exp_r.score, got.score); errors++;
      end
      if (got.slot !== exp_r.slot) begin
         $error("arrival_slot expected %0d got %0d", exp_r.slot, got.slot); errors++;
      end
      if (got.overflowed !== exp_r.overflowed) begin
         $error("overflowed expected %0d got %0d", exp_r.overflowed, got.overflowed);
         errors++;
      end
      if (got.last !== exp_r.last) begin
         $error("last_out expected %0d got %0d", exp_r.last, got.last); errors++;
      end
   endfunction
endclass

module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   logic clock = 0, reset = 1;
   logic push = 0, pop = 0, csr_wr_en = 0;
   logic full, empty;
   logic signed [15:0] req_box_left = 0, req_box_top = 0, req_box_right = 0, req_box_bottom = 0;
   logic [15:0] req_box_score = 0;
   logic req_last_in = 0;
   logic [16:0] csr_wr_data = 0;
   logic signed [15:0] rsp_out_left, rsp_out_top, rsp_out_right, rsp_out_bottom;
   logic [15:0] rsp_out_score;
   logic [5:0] rsp_arrival_slot;
   logic rsp_overflowed, rsp_last_out;

   nms_scoreboard sb = new();
   bit send_idle, recv_stall;
   int hold_cycles = 0;

   greedy_box_nms_unit u_top (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   initial begin
      #20ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   // result side
   initial begin
      gnms_pkg::result_type got;
      forever begin
         @(negedge clock);
         if (hold_cycles > 0) begin
            hold_cycles--;
            pop = 0;
         end else begin
            pop = !(recv_stall && $urandom_range(99) < 71);
         end
         @(posedge clock);
         if (pop && !empty && !reset) begin
            got.left = rsp_out_left; got.top = rsp_out_top;
            got.right = rsp_out_right; got.bottom = rsp_out_bottom;
            got.score = rsp_out_score; got.slot = rsp_arrival_slot;
            got.overflowed = rsp_overflowed; got.last = rsp_last_out;
            sb.check_result(got);
         end
      end
   end

   task automatic send_box(int l, t, r, b, int s, bit last);
      while (send_idle && $urandom_range(99) < 71) begin
         push = 0;
         @(negedge clock);
      end
      push = 1;
      req_box_left = l[15:0]; req_box_top = t[15:0];
      req_box_right = r[15:0]; req_box_bottom = b[15:0];
      req_box_score = s[15:0]; req_last_in = last;
      do @(posedge clock); while (full);
      sb.note_request(req_box_left, req_box_top, req_box_right, req_box_bottom,
                      req_box_score, last);
      @(negedge clock);
   endtask

   task automatic send_set(int n);
      int cx, cy, l, t, w, h, s, kind;
      cx = $urandom_range(200) - 100;
      cy = $urandom_range(200) - 100;
      for (int i = 0; i < n; i++) begin
         kind = $urandom_range(99);
         s = ($urandom_range(3) == 0) ? $urandom_range(3) * 100 : $urandom_range(65535);
         if (kind < 10) begin
            send_box($urandom, $urandom, $urandom, $urandom, s, i == n - 1);
         end else begin
            l = cx + $urandom_range(60) - 30;
            t = cy + $urandom_range(60) - 30;
            w = (kind < 16) ? -$urandom_range(5) : $urandom_range(60, 1);
            h = (kind < 16) ? $urandom_range(5) : $urandom_range(60, 1);
            send_box(l, t, l + w, t + h, s, i == n - 1);
         end
      end
      push = 0;
   endtask

   task automatic drain();
      push = 0;
      while (sb.survivors_q.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
   endtask

   task automatic write_threshold(int v);
      csr_wr_en = 1;
      csr_wr_data = v[16:0];
      @(negedge clock);
      csr_wr_en = 0;
      sb.thr = v[16:0];
   endtask

   initial begin
      int thr_list[8];
      int sent;
      thr_list = '{0, 65536, 131071, 1, 19661, 65535, 32768, 98304};
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 0;
      // directed: extremes, ties, identical, disjoint, touching, degenerate
      send_box(-32768, -32768, 32767, 32767, 65535, 1);
      send_box(32767, 32767, -32768, -32768, 0, 1);
      send_box(0, 0, 10, 10, 500, 0);
      send_box(0, 0, 10, 10, 500, 0);
      send_box(1, 1, 11, 11, 500, 0);
      send_box(10, 0, 20, 10, 900, 0);
      send_box(20, 0, 30, 10, 0, 0);
      send_box(5, 5, 5, 20, 65535, 0);
      send_box(-32768, -32768, 32767, 32767, 1, 0);
      send_box(2, 0, 10, 10, 500, 1);
      push = 0;
      drain();
      for (int p = 0; p < 8; p++) begin
         send_idle = (p % 4 == 1) || (p % 4 == 3);
         recv_stall = (p % 4 == 2) || (p % 4 == 3);
         write_threshold((p == 7) ? $urandom_range(131071) : thr_list[p]);
         if (p == 0) begin
            // result register and back end held, so the queue fills
            hold_cycles = 600;
            send_set(1);
            send_set(1);
            send_set(8);
         end
         if (p == 2) send_set(64);
         if (p == 5) send_set(66);
         sent = 0;
         while (sent < 2) begin
            int n;
            n = $urandom_range(9, 1);
            send_set(n);
            sent += n;
         end
         drain();
      end
      if (sb.errors == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end
endmodule
`default_nettype wire

/* sim.f */
+incdir+design
design/gnms_pkg.sv
design/gnms_front.sv
design/gnms_fifo.sv
design/gnms_back.sv
design/greedy_box_nms_unit.sv
bench/tb_top.sv
